### design/sst_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted set table
// used by sst_cell, sst_group_or and sorted_set_table_top
package sst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;
    // cells per first-level group of the flag reduction
    localparam int GROUP_SIZE   = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MEMBER      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ_MIN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_MAX    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EXTRACT_MIN = 3'd5;
    localparam logic [KIND_W-1:0] KIND_EXTRACT_MAX = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] out_value;
        logic [COUNT_W-1:0]      entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_DELETE,
        CMD_POP_FRONT,
        CMD_POP_BACK
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t               cmd;
        logic signed [KEY_W-1:0] key;
    } cell_ctrl_t;

    typedef struct packed {
        logic                    valid;
        logic                    lt;
        logic signed [KEY_W-1:0] entry;
    } cell_link_t;

endpackage

### design/sst_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted chain: holds an entry and its valid bit
// depends on sst_pkg for the control and neighbor link structs
module sst_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sst_pkg::cell_ctrl_t              ctrl_i,
    input  sst_pkg::cell_link_t              left_i,
    input  sst_pkg::cell_link_t              right_i,
    output sst_pkg::cell_link_t              link_o,
    output logic                             found_o,
    output logic signed [sst_pkg::KEY_W-1:0] max_word_o
);

    logic signed [sst_pkg::KEY_W-1:0] entry_reg, entry_next;
    logic                             valid_reg, valid_next;
    logic                             lt;

    assign lt         = valid_reg && (entry_reg < ctrl_i.key);
    assign found_o    = valid_reg && (entry_reg == ctrl_i.key);
    // only the topmost valid cell shows its entry to the max reduction
    assign max_word_o = (valid_reg && !right_i.valid) ? entry_reg : '0;

    assign link_o.valid = valid_reg;
    assign link_o.lt    = lt;
    assign link_o.entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (ctrl_i.cmd)
            sst_pkg::CMD_INSERT: begin
                valid_next = left_i.valid;
                if (!lt) begin
                    entry_next = left_i.lt ? ctrl_i.key : left_i.entry;
                end
            end
            sst_pkg::CMD_DELETE: begin
                valid_next = right_i.valid;
                if (!lt) begin
                    entry_next = right_i.entry;
                end
            end
            sst_pkg::CMD_POP_FRONT: begin
                valid_next = right_i.valid;
                entry_next = right_i.entry;
            end
            sst_pkg::CMD_POP_BACK: begin
                valid_next = valid_reg && right_i.valid;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

endmodule

### design/sst_group_or.sv
`timescale 1ns / 1ps
// registered first-level reduction over a group of cells: match flag and max word
// depends on sst_pkg for the key width
module sst_group_or #(
    parameter int GROUP = sst_pkg::GROUP_SIZE
) (
    input  logic                                   aclk,
    input  logic [GROUP-1:0]                       found_i,
    input  logic [GROUP-1:0][sst_pkg::KEY_W-1:0]   word_i,
    output logic                                   found_o,
    output logic [sst_pkg::KEY_W-1:0]              word_o
);

    logic                      found_reg;
    logic [sst_pkg::KEY_W-1:0] word_reg, word_next;

    always_comb begin
        word_next = '0;
        for (int j = 0; j < GROUP; j++) begin
            word_next = word_next | word_i[j];
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= |found_i;
        word_reg  <= word_next;
    end

    assign found_o = found_reg;
    assign word_o  = word_reg;

endmodule

### design/sorted_set_table_top.sv
`timescale 1ns / 1ps
// sorted set table: a chain of compare-and-shift cells with a two-level flag reduction
// depends on sst_pkg, sst_cell and sst_group_or
//
// usage
//   s_valid/s_ready/s_data carry one request (kind, key_value); m_valid/m_ready/m_data
//   return exactly one result per request (status, out_value, entry_count).
//   every cell compares its entry with the request key in parallel; the match flags and
//   the topmost entry are folded through a registered group stage, then the apply state
//   shifts the chain up or down by one slot (or drops the top entry for extract max)
//   and loads the output register. a request passes the request register, the group
//   register and the apply state before its result is on m_data; no request is taken
//   during gather, and a new request is taken in the same cycle its predecessor applies.
//   reset clears the cell valid bits, the entry count and the output valid; entry
//   payloads are not cleared and no clearing pass runs, the block is ready at once.
//   if the receiver stalls, the finished result holds in the output register, one more
//   request is taken and compared, and its apply waits until the output frees.
module sorted_set_table_top #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sst_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sst_pkg::rsp_t m_data
);

    localparam int GROUP      = sst_pkg::GROUP_SIZE;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam int PAD        = NUM_GROUPS * GROUP;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int KEY_W      = sst_pkg::KEY_W;

    localparam sst_pkg::cell_link_t LINK_LEFT_EDGE  = '{valid: 1'b1, lt: 1'b1, entry: '0};
    localparam sst_pkg::cell_link_t LINK_RIGHT_EDGE = '{valid: 1'b0, lt: 1'b0, entry: '0};

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_APPLY
    } state_t;

    state_t             state_reg;
    sst_pkg::req_t      req_reg;
    sst_pkg::rsp_t      m_data_reg;
    logic               m_valid_reg;
    logic [CNT_W-1:0]   count_reg;

    sst_pkg::cell_ctrl_t ctrl;
    sst_pkg::cell_cmd_t  cmd;
    sst_pkg::cell_link_t links [CAPACITY];
    logic [PAD-1:0]             found_pad;
    logic [PAD-1:0][KEY_W-1:0]  word_pad;
    logic [NUM_GROUPS-1:0]      group_found;
    logic [KEY_W-1:0]           group_word [NUM_GROUPS];

    logic               out_free;
    logic               apply_fire;
    logic               accept;
    logic               found_all;
    logic               empty;
    logic               full;
    logic [KEY_W-1:0]   max_value;
    logic [CNT_W-1:0]   count_next;
    logic [31:0]        count_ext;
    sst_pkg::rsp_t      rsp;

    assign out_free   = !m_valid_reg || m_ready;
    assign apply_fire = (state_reg == S_APPLY) && out_free;
    assign s_ready    = (state_reg == S_IDLE) || apply_fire;
    assign accept     = s_valid && s_ready;

    assign ctrl.cmd = apply_fire ? cmd : sst_pkg::CMD_NONE;
    assign ctrl.key = req_reg.key_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        sst_pkg::cell_link_t left_link, right_link;
        logic                found_w;
        logic [KEY_W-1:0]    word_w;
        if (i == 0) begin : g_first
            assign left_link = LINK_LEFT_EDGE;
        end else begin : g_mid_l
            assign left_link = links[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_link = LINK_RIGHT_EDGE;
        end else begin : g_mid_r
            assign right_link = links[i+1];
        end
        sst_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl_i     (ctrl),
            .left_i     (left_link),
            .right_i    (right_link),
            .link_o     (links[i]),
            .found_o    (found_w),
            .max_word_o (word_w)
        );
        assign found_pad[i] = found_w;
        assign word_pad[i]  = word_w;
    end

    for (genvar i = CAPACITY; i < PAD; i++) begin : g_pad
        assign found_pad[i] = 1'b0;
        assign word_pad[i]  = '0;
    end

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
        sst_group_or #(
            .GROUP (GROUP)
        ) u_group (
            .aclk    (aclk),
            .found_i (found_pad[g*GROUP +: GROUP]),
            .word_i  (word_pad[g*GROUP +: GROUP]),
            .found_o (group_found[g]),
            .word_o  (group_word[g])
        );
    end

    always_comb begin
        max_value = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            max_value = max_value | group_word[g];
        end
    end

    assign found_all = |group_found;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= CNT_W'(CAPACITY));

    always_comb begin
        cmd           = sst_pkg::CMD_NONE;
        count_next    = count_reg;
        rsp.status    = sst_pkg::STATUS_MISS;
        rsp.out_value = '0;
        case (req_reg.kind) inside
            sst_pkg::KIND_INSERT: begin
                if (found_all) begin
                    rsp.status = sst_pkg::STATUS_MISS;
                end else if (full) begin
                    rsp.status = sst_pkg::STATUS_FULL;
                end else begin
                    rsp.status = sst_pkg::STATUS_OK;
                    cmd        = sst_pkg::CMD_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            sst_pkg::KIND_REMOVE: begin
                if (found_all) begin
                    rsp.status = sst_pkg::STATUS_OK;
                    cmd        = sst_pkg::CMD_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            sst_pkg::KIND_MEMBER: begin
                if (found_all) begin
                    rsp.status = sst_pkg::STATUS_OK;
                end
            end
            sst_pkg::KIND_READ_MIN, sst_pkg::KIND_EXTRACT_MIN: begin
                if (!empty) begin
                    rsp.status    = sst_pkg::STATUS_OK;
                    rsp.out_value = links[0].entry;
                    if (req_reg.kind == sst_pkg::KIND_EXTRACT_MIN) begin
                        cmd        = sst_pkg::CMD_POP_FRONT;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            sst_pkg::KIND_READ_MAX, sst_pkg::KIND_EXTRACT_MAX: begin
                if (!empty) begin
                    rsp.status    = sst_pkg::STATUS_OK;
                    rsp.out_value = max_value;
                    if (req_reg.kind == sst_pkg::KIND_EXTRACT_MAX) begin
                        cmd        = sst_pkg::CMD_POP_BACK;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                rsp.status = sst_pkg::STATUS_MISS;
            end
        endcase
        count_ext       = 32'(count_next);
        rsp.entry_count = count_ext[sst_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (apply_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg   <= s_data;
                        state_reg <= S_GATHER;
                    end
                end
                S_GATHER: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (out_free) begin
                        m_data_reg  <= rsp;
                        count_reg   <= count_next;
                        if (s_valid) begin
                            req_reg   <= s_data;
                            state_reg <= S_GATHER;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // the bottom cell is valid exactly when the store holds something
    a_first_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        links[0].valid == (count_reg != '0))
        else $error("bottom cell valid disagrees with entry count");

    // the top cell only fills when the store is full
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        links[CAPACITY-1].valid |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("top cell valid while store not full");

    // a full report is only given with the store at capacity
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == sst_pkg::STATUS_FULL))
            |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status while store has room");

    // an applied insert grows the count by one
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply_fire && (cmd == sst_pkg::CMD_INSERT))
            |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not bump entry count");
`endif

endmodule

### tb/sv/sorted_set_table_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_set_table_top: random and directed requests
// against a queue-based shadow of the sorted store; depends on sst_pkg and the design
module sorted_set_table_top_tb;

    localparam int KEY_W       = sst_pkg::KEY_W;
    localparam int KIND_W      = sst_pkg::KIND_W;
    localparam int COUNT_W     = sst_pkg::COUNT_W;
    localparam int TABLE_DEPTH = sst_pkg::CAPACITY_DEF;
    localparam int RANDOM_REQS = 1200;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    // shadow of the sorted store plus the responses still owed by the block
    class sorted_set_shadow;
        logic signed [KEY_W-1:0] held_keys[$];
        sst_pkg::rsp_t awaited_rsp[$];
        int failures;

        function new();
            failures = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_MAX)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction

        function void note_request(sst_pkg::req_t r);
            sst_pkg::rsp_t exp;
            int pos;
            bit found;
            exp.status = sst_pkg::STATUS_MISS;
            exp.out_value = '0;
            pos = 0;
            while (pos < held_keys.size() && held_keys[pos] < r.key_value)
                pos++;
            found = (pos < held_keys.size()) && (held_keys[pos] == r.key_value);
            case (r.kind) inside
                sst_pkg::KIND_INSERT: begin
                    // duplicate wins over full
                    if (found)
                        exp.status = sst_pkg::STATUS_MISS;
                    else if (held_keys.size() >= TABLE_DEPTH)
                        exp.status = sst_pkg::STATUS_FULL;
                    else begin
                        held_keys.insert(pos, r.key_value);
                        exp.status = sst_pkg::STATUS_OK;
                    end
                end
                sst_pkg::KIND_REMOVE, sst_pkg::KIND_MEMBER: begin
                    if (found) begin
                        exp.status = sst_pkg::STATUS_OK;
                        if (r.kind == sst_pkg::KIND_REMOVE)
                            held_keys.delete(pos);
                    end
                end
                sst_pkg::KIND_READ_MIN, sst_pkg::KIND_EXTRACT_MIN: begin
                    if (held_keys.size() > 0) begin
                        exp.out_value = held_keys[0];
                        exp.status = sst_pkg::STATUS_OK;
                        if (r.kind == sst_pkg::KIND_EXTRACT_MIN)
                            void'(held_keys.pop_front());
                    end
                end
                sst_pkg::KIND_READ_MAX, sst_pkg::KIND_EXTRACT_MAX: begin
                    if (held_keys.size() > 0) begin
                        exp.out_value = held_keys[held_keys.size() - 1];
                        exp.status = sst_pkg::STATUS_OK;
                        if (r.kind == sst_pkg::KIND_EXTRACT_MAX)
                            void'(held_keys.pop_back());
                    end
                end
                default: begin
                end
            endcase
            exp.entry_count = COUNT_W'(held_keys.size());
            awaited_rsp.push_back(exp);
        endfunction

        function void check_result(sst_pkg::rsp_t got);
            sst_pkg::rsp_t exp;
            if (awaited_rsp.size() == 0) begin
                note_failure($sformatf("unexpected result status=%0d value=%0d count=%0d",
                                       got.status, got.out_value, got.entry_count));
                return;
            end
            exp = awaited_rsp.pop_front();
            if (got.status !== exp.status || got.out_value !== exp.out_value ||
                got.entry_count !== exp.entry_count)
                note_failure($sformatf(
                    "status exp %0d got %0d, value exp %0d got %0d, count exp %0d got %0d",
                    exp.status, got.status, exp.out_value, got.out_value,
                    exp.entry_count, got.entry_count));
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    sst_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    sst_pkg::rsp_t m_data;

    sorted_set_shadow shadow;
    bit quiet_stretch;
    int stall_cycles;

    sorted_set_table_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= quiet_stretch || ($urandom_range(0, 99) >= 23);
    end

    // both handshakes sampled on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                shadow.note_request(s_data);
            if (m_valid && m_ready)
                shadow.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[sorted_set_table_top] ERROR");
                $finish;
            end
        end
    end

    // entered and left just after a falling edge; valid holds until the request is taken
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [KEY_W-1:0] key);
        bit taken;
        while (!quiet_stretch && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data.kind <= kind;
        s_data.key_value <= key;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_ready;
            @(negedge aclk);
        end
    endtask

    function automatic logic signed [KEY_W-1:0] edge_key();
        case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return -1;
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] held_key_or_random();
        int n;
        n = shadow.held_keys.size();
        if (n == 0)
            return $urandom;
        return shadow.held_keys[$urandom_range(0, n - 1)];
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(logic [KIND_W-1:0] kind);
        int r;
        r = $urandom_range(0, 99);
        if (kind == sst_pkg::KIND_INSERT) begin
            if (r < 60)
                return $urandom;
            else if (r < 85)
                return $signed($urandom_range(0, 32)) - 16;
            else if (r < 95)
                return edge_key();
            return held_key_or_random();
        end
        if (r < 60)
            return held_key_or_random();
        else if (r < 85)
            return $signed($urandom_range(0, 32)) - 16;
        else if (r < 92)
            return edge_key();
        return $urandom;
    endfunction

    // phase 0 fills toward full, phase 1 is mixed, phase 2 drains
    function automatic logic [KIND_W-1:0] pick_kind(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return KIND_UNUSED;
        case (phase)
            0: begin
                if (r < 67) return sst_pkg::KIND_INSERT;
                if (r < 75) return sst_pkg::KIND_REMOVE;
                if (r < 85) return sst_pkg::KIND_MEMBER;
                return logic'(r[0]) ? sst_pkg::KIND_READ_MIN : sst_pkg::KIND_READ_MAX;
            end
            2: begin
                if (r < 17) return sst_pkg::KIND_INSERT;
                if (r < 47) return sst_pkg::KIND_REMOVE;
                if (r < 57) return sst_pkg::KIND_MEMBER;
                if (r < 92)
                    return logic'(r[0]) ? sst_pkg::KIND_EXTRACT_MIN
                                        : sst_pkg::KIND_EXTRACT_MAX;
                return logic'(r[0]) ? sst_pkg::KIND_READ_MIN : sst_pkg::KIND_READ_MAX;
            end
            default: return KIND_W'($urandom_range(0, 6));
        endcase
    endfunction

    initial begin
        logic [KIND_W-1:0] kind;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        quiet_stretch = 1'b0;
        shadow = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty store, absent keys and the unused kind
        send_request(sst_pkg::KIND_READ_MIN, 32'sd9);
        send_request(sst_pkg::KIND_READ_MAX, 32'sd9);
        send_request(sst_pkg::KIND_EXTRACT_MIN, 32'sd0);
        send_request(sst_pkg::KIND_EXTRACT_MAX, 32'sd0);
        send_request(sst_pkg::KIND_REMOVE, 32'sd5);
        send_request(sst_pkg::KIND_MEMBER, 32'sd5);
        send_request(KIND_UNUSED, KEY_MAX);
        // extremes in and out of order, then a duplicate
        send_request(sst_pkg::KIND_INSERT, 32'sd0);
        send_request(sst_pkg::KIND_INSERT, KEY_MIN);
        send_request(sst_pkg::KIND_INSERT, KEY_MAX);
        send_request(sst_pkg::KIND_INSERT, -32'sd1);
        send_request(sst_pkg::KIND_INSERT, 32'sd0);
        send_request(sst_pkg::KIND_MEMBER, -32'sd1);
        send_request(sst_pkg::KIND_MEMBER, 32'sd7);
        send_request(sst_pkg::KIND_READ_MIN, 32'sd0);
        send_request(sst_pkg::KIND_READ_MAX, 32'sd0);
        send_request(KIND_UNUSED, KEY_MIN);
        send_request(sst_pkg::KIND_EXTRACT_MIN, 32'sd0);
        send_request(sst_pkg::KIND_EXTRACT_MAX, 32'sd0);
        send_request(sst_pkg::KIND_REMOVE, -32'sd1);
        send_request(sst_pkg::KIND_REMOVE, -32'sd1);
        send_request(sst_pkg::KIND_INSERT, 32'sd5);
        send_request(sst_pkg::KIND_EXTRACT_MIN, 32'sd0);
        send_request(sst_pkg::KIND_EXTRACT_MAX, 32'sd0);
        send_request(sst_pkg::KIND_EXTRACT_MAX, 32'sd0);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            quiet_stretch = (i >= 400 && i < 600);
            // hold off until the block has drained
            if (i == 800) begin
                s_valid <= 1'b0;
                while (shadow.pending() != 0)
                    @(negedge aclk);
            end
            kind = pick_kind((i / 150) % 3);
            send_request(kind, pick_key(kind));
        end
        s_valid <= 1'b0;
        quiet_stretch = 1'b0;

        while (shadow.pending() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (shadow.pending() != 0)
            shadow.note_failure("responses still outstanding at end of run");

        if (shadow.failures == 0)
            $display("[sorted_set_table_top] OK");
        else
            $display("[sorted_set_table_top] ERROR");
        $finish;
    end
endmodule

### sim.f
design/sst_pkg.sv
design/sst_cell.sv
design/sst_group_or.sv
design/sorted_set_table_top.sv
tb/sv/sorted_set_table_top_tb.sv
